// ----- hdl/emabd_pkg.sv -----
// ============================================================================
// emabd_pkg: shared types and constants for the EMA temperature band display
// Widths, register reset values, field codes and transaction structs used by
// every module of the block.
// ============================================================================
package emabd_pkg;

    // Filter widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 16;
    localparam int ALPHA_BITS    = 16;
    localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
    localparam int PROD_BITS     = ALPHA_BITS + AVG_BITS;
    localparam logic [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'((64'd1 << ALPHA_BITS) - 64'd1);

    // Display and band widths
    localparam int LIMIT_BITS = 12;
    localparam int CMP_BITS   = (AVG_BITS > LIMIT_BITS + FRACTION_BITS) ?
                                AVG_BITS : LIMIT_BITS + FRACTION_BITS;
    localparam int MV_BITS    = 12;
    localparam int MV_MAX     = 4095;
    localparam int DUTY_BITS  = 8;
    localparam int TENS_BITS  = 6;
    localparam int DIGIT_BITS = 4;
    localparam int Q10_BITS   = 9;
    localparam int QPROD_BITS = MV_BITS + 16;

    // Reciprocal constants for divide by 100 and by 10 (exact for 12-bit values)
    localparam logic [15:0] DIV100_MUL   = 16'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [15:0] DIV10_MUL    = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LED_DUTY   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SERVO_LOW  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SERVO_MID  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SERVO_HIGH = 3'd6;

    // Register reset values
    localparam logic [ALPHA_BITS-1:0] RST_SMOOTHING  = 16'd3277;
    localparam logic [LIMIT_BITS-1:0] RST_LOW_LIMIT  = 12'd200;
    localparam logic [LIMIT_BITS-1:0] RST_HIGH_LIMIT = 12'd400;
    localparam logic [DUTY_BITS-1:0]  RST_LED_DUTY   = 8'd191;
    localparam logic [DUTY_BITS-1:0]  RST_SERVO_LOW  = 8'd17;
    localparam logic [DUTY_BITS-1:0]  RST_SERVO_MID  = 8'd22;
    localparam logic [DUTY_BITS-1:0]  RST_SERVO_HIGH = 8'd27;

    // Item mode codes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Band codes
    localparam logic [1:0] BAND_NONE  = 2'd0;
    localparam logic [1:0] BAND_GREEN = 2'd1;
    localparam logic [1:0] BAND_BLUE  = 2'd2;
    localparam logic [1:0] BAND_RED   = 2'd3;

    // Scan positions
    localparam logic [1:0] SCAN_TENS   = 2'd0;
    localparam logic [1:0] SCAN_UNITS  = 2'd1;
    localparam logic [1:0] SCAN_TENTHS = 2'd2;

    typedef struct packed {
        logic                   mode;
        logic [SAMPLE_BITS-1:0] sample_mv;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            band;
        logic [DUTY_BITS-1:0]  red_duty;
        logic [DUTY_BITS-1:0]  green_duty;
        logic [DUTY_BITS-1:0]  blue_duty;
        logic [DUTY_BITS-1:0]  servo_duty;
        logic [TENS_BITS-1:0]  tens_digit;
        logic [DIGIT_BITS-1:0] units_digit;
        logic [DIGIT_BITS-1:0] tenths_digit;
        logic [MV_BITS-1:0]    filtered_mv;
        logic [2:0]            digit_enable;
        logic [TENS_BITS-1:0]  shown_digit;
        logic                  point_on;
    } out_item_t;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] smoothing_factor;
        logic [LIMIT_BITS-1:0] low_limit;
        logic [LIMIT_BITS-1:0] high_limit;
        logic [DUTY_BITS-1:0]  led_duty;
        logic [DUTY_BITS-1:0]  servo_low;
        logic [DUTY_BITS-1:0]  servo_mid;
        logic [DUTY_BITS-1:0]  servo_high;
    } cfg_t;

    // Item moving from the filter stage to the display stage
    typedef struct packed {
        logic valid;
        logic mode;
    } stage_t;

endpackage

// ----- hdl/ema_temperature_band_display.sv -----
// ============================================================================
// ema_temperature_band_display: filtered temperature band and digit display
// Moving average filter on millivolt samples, decimal digit split, band
// selection with LED and servo duties, and a three-digit display scan.
// ============================================================================
//
//  channel   signals                        direction  payload
//  --------  -----------------------------  ---------  -------------------
//  in        in_valid / in_ready / in_data  input      mode, sample_mv
//  out       out_valid / out_ready          output     out_data result
//  cfg       cfg_valid / cfg_ready          input      cfg_index, cfg_data
//
//  One transaction per cycle sustained while out_ready stays high; each result
//  passes the input register (loaded at the accepting edge), then the average
//  update, then the result register.
//  The average update (one 16x28 multiply-add) is the loop that sets the rate.
//  Reset clears the average, held digits, band and scan and loads the
//  register defaults; cfg_ready is always high.
//  A stalled output fills the stages behind it one by one, then in_ready drops.
//
module ema_temperature_band_display (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  emabd_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output emabd_pkg::out_item_t                 out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [emabd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [emabd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    emabd_pkg::cfg_t                  cfg;
    emabd_pkg::stage_t                stage;
    logic [emabd_pkg::AVG_BITS-1:0]   average;
    logic                             take;

    emabd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    emabd_filter u_filter (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .smoothing_factor (cfg.smoothing_factor),
        .take             (take),
        .stage            (stage),
        .average          (average)
    );

    emabd_display u_display (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .average   (average),
        .cfg       (cfg),
        .take      (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- hdl/emabd_cfg_regs.sv -----
// ============================================================================
// emabd_cfg_regs: configuration register file
// Seven registers written through the config channel; unknown indexes ignored.
// ============================================================================
module emabd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [emabd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [emabd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output emabd_pkg::cfg_t                      cfg
);

    emabd_pkg::cfg_t cfg_reg;
    emabd_pkg::cfg_t cfg_next;

    // Writes are always accepted
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode, data masked to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                emabd_pkg::REG_SMOOTHING:
                    cfg_next.smoothing_factor = cfg_data[emabd_pkg::ALPHA_BITS-1:0];
                emabd_pkg::REG_LOW_LIMIT:
                    cfg_next.low_limit = cfg_data[emabd_pkg::LIMIT_BITS-1:0];
                emabd_pkg::REG_HIGH_LIMIT:
                    cfg_next.high_limit = cfg_data[emabd_pkg::LIMIT_BITS-1:0];
                emabd_pkg::REG_LED_DUTY:
                    cfg_next.led_duty = cfg_data[emabd_pkg::DUTY_BITS-1:0];
                emabd_pkg::REG_SERVO_LOW:
                    cfg_next.servo_low = cfg_data[emabd_pkg::DUTY_BITS-1:0];
                emabd_pkg::REG_SERVO_MID:
                    cfg_next.servo_mid = cfg_data[emabd_pkg::DUTY_BITS-1:0];
                emabd_pkg::REG_SERVO_HIGH:
                    cfg_next.servo_high = cfg_data[emabd_pkg::DUTY_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_factor <= emabd_pkg::RST_SMOOTHING;
            cfg_reg.low_limit        <= emabd_pkg::RST_LOW_LIMIT;
            cfg_reg.high_limit       <= emabd_pkg::RST_HIGH_LIMIT;
            cfg_reg.led_duty         <= emabd_pkg::RST_LED_DUTY;
            cfg_reg.servo_low        <= emabd_pkg::RST_SERVO_LOW;
            cfg_reg.servo_mid        <= emabd_pkg::RST_SERVO_MID;
            cfg_reg.servo_high       <= emabd_pkg::RST_SERVO_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/emabd_filter.sv -----
// ============================================================================
// emabd_filter: input register and moving average update
// Registers each input transaction, then for sample items applies
// average += alpha * (sample - average) with floor rounding.
// ============================================================================
module emabd_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  emabd_pkg::in_item_t                 in_data,
    input  logic [emabd_pkg::ALPHA_BITS-1:0]    smoothing_factor,
    input  logic                                take,
    output emabd_pkg::stage_t                   stage,
    output logic [emabd_pkg::AVG_BITS-1:0]      average
);

    // Input register
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    emabd_pkg::in_item_t  s1_reg;

    // Update stage
    emabd_pkg::stage_t    s2_reg;
    emabd_pkg::stage_t    s2_next;
    logic [emabd_pkg::AVG_BITS-1:0]  average_reg;
    logic [emabd_pkg::AVG_BITS-1:0]  average_next;

    logic                                s2_free;
    logic                                advance;
    logic [emabd_pkg::AVG_BITS-1:0]      target;
    logic                                rising;
    logic [emabd_pkg::AVG_BITS-1:0]      mag;
    logic [emabd_pkg::PROD_BITS-1:0]     prod;
    logic [emabd_pkg::PROD_BITS-1:0]     rounded;
    logic [emabd_pkg::AVG_BITS-1:0]      step;

    // Flow control: each stage moves when the one after it has room
    assign s2_free  = !s2_reg.valid || take;
    assign advance  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || advance;

    assign stage   = s2_reg;
    assign average = average_reg;

    // Moving average step: ceil on the way down gives floor of the exact result
    always_comb
    begin
        target  = emabd_pkg::AVG_BITS'(s1_reg.sample_mv) << emabd_pkg::FRACTION_BITS;
        rising  = target >= average_reg;
        mag     = rising ? (target - average_reg) : (average_reg - target);
        prod    = emabd_pkg::PROD_BITS'(smoothing_factor) * emabd_pkg::PROD_BITS'(mag);
        rounded = rising ? prod : (prod + emabd_pkg::ROUND_BIAS);
        step    = emabd_pkg::AVG_BITS'(rounded >> emabd_pkg::ALPHA_BITS);

        average_next = average_reg;
        if (advance && (s1_reg.mode == emabd_pkg::MODE_SAMPLE))
        begin
            average_next = rising ? (average_reg + step) : (average_reg - step);
        end
    end

    // Stage valid bookkeeping
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        s2_next = s2_reg;
        if (advance)
        begin
            s2_next.valid = 1'b1;
            s2_next.mode  = s1_reg.mode;
        end
        else if (take)
        begin
            s2_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_reg       <= '0;
            average_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_reg       <= s2_next;
            average_reg  <= average_next;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_reg <= in_data;
    end

    // The average only moves when a sample passes into the update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && (s1_reg.mode == emabd_pkg::MODE_SAMPLE)) |=> $stable(average_reg))
        else $error("average changed without a sample");

    // An update-stage item is held until the display stage takes it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_reg.valid && !take) |=> (s2_reg.valid && $stable(s2_reg.mode)))
        else $error("update stage item dropped");

    // Input register is only loaded when it is empty or emptying
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !in_ready)
        else $error("input register overwritten");

endmodule

// ----- hdl/emabd_display.sv -----
// ============================================================================
// emabd_display: digit split, band decision, display scan and result register
// Holds the digits, band and scan position and builds each result transaction.
// ============================================================================
module emabd_display (
    input  logic                            clk,
    input  logic                            rst_n,
    input  emabd_pkg::stage_t               stage,
    input  logic [emabd_pkg::AVG_BITS-1:0]  average,
    input  emabd_pkg::cfg_t                 cfg,
    output logic                            take,
    output logic                            out_valid,
    input  logic                            out_ready,
    output emabd_pkg::out_item_t            out_data
);

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    emabd_pkg::out_item_t                  out_reg;
    emabd_pkg::out_item_t                  out_next;

    logic [1:0]                            scan_reg;
    logic [1:0]                            scan_next;
    logic [emabd_pkg::TENS_BITS-1:0]       tens_reg;
    logic [emabd_pkg::TENS_BITS-1:0]       tens_next;
    logic [emabd_pkg::DIGIT_BITS-1:0]      units_reg;
    logic [emabd_pkg::DIGIT_BITS-1:0]      units_next;
    logic [emabd_pkg::DIGIT_BITS-1:0]      tenths_reg;
    logic [emabd_pkg::DIGIT_BITS-1:0]      tenths_next;
    logic [1:0]                            band_reg;
    logic [1:0]                            band_next;

    logic [emabd_pkg::AVG_BITS-1:0]        whole;
    logic [emabd_pkg::MV_BITS-1:0]         mv;
    logic [emabd_pkg::QPROD_BITS-1:0]      q100_prod;
    logic [emabd_pkg::QPROD_BITS-1:0]      q10_prod;
    logic [emabd_pkg::TENS_BITS-1:0]       q100;
    logic [emabd_pkg::Q10_BITS-1:0]        q10;
    logic [emabd_pkg::Q10_BITS-1:0]        units_full;
    logic [emabd_pkg::MV_BITS-1:0]         tenths_full;
    logic [emabd_pkg::CMP_BITS-1:0]        avg_cmp;
    logic [emabd_pkg::CMP_BITS-1:0]        lo_cmp;
    logic [emabd_pkg::CMP_BITS-1:0]        hi_cmp;
    logic [1:0]                            band_calc;
    logic                                  is_sample;

    assign take      = stage.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign is_sample = stage.mode == emabd_pkg::MODE_SAMPLE;

    // Integer millivolts, saturated, and its decimal digits by reciprocal
    always_comb
    begin
        whole = average >> emabd_pkg::FRACTION_BITS;
        mv    = (whole > emabd_pkg::AVG_BITS'(emabd_pkg::MV_MAX)) ?
                emabd_pkg::MV_BITS'(emabd_pkg::MV_MAX) : whole[emabd_pkg::MV_BITS-1:0];
        q100_prod = emabd_pkg::QPROD_BITS'(mv) *
                    emabd_pkg::QPROD_BITS'(emabd_pkg::DIV100_MUL);
        q10_prod  = emabd_pkg::QPROD_BITS'(mv) *
                    emabd_pkg::QPROD_BITS'(emabd_pkg::DIV10_MUL);
        q100 = emabd_pkg::TENS_BITS'(q100_prod >> emabd_pkg::DIV100_SHIFT);
        q10  = emabd_pkg::Q10_BITS'(q10_prod >> emabd_pkg::DIV10_SHIFT);
        units_full  = q10 - ((emabd_pkg::Q10_BITS'(q100) << 3) +
                             (emabd_pkg::Q10_BITS'(q100) << 1));
        tenths_full = mv - ((emabd_pkg::MV_BITS'(q10) << 3) +
                            (emabd_pkg::MV_BITS'(q10) << 1));
    end

    // Band decision on the exact fixed-point average
    always_comb
    begin
        avg_cmp = emabd_pkg::CMP_BITS'(average);
        lo_cmp  = emabd_pkg::CMP_BITS'(cfg.low_limit) << emabd_pkg::FRACTION_BITS;
        hi_cmp  = emabd_pkg::CMP_BITS'(cfg.high_limit) << emabd_pkg::FRACTION_BITS;
        if (avg_cmp > hi_cmp)
            band_calc = emabd_pkg::BAND_RED;
        else if (avg_cmp >= lo_cmp)
            band_calc = emabd_pkg::BAND_BLUE;
        else
            band_calc = emabd_pkg::BAND_GREEN;
    end

    // Held state: samples refresh digits and band, ticks advance the scan
    always_comb
    begin
        tens_next   = tens_reg;
        units_next  = units_reg;
        tenths_next = tenths_reg;
        band_next   = band_reg;
        scan_next   = scan_reg;
        if (take)
        begin
            if (is_sample)
            begin
                tens_next   = q100;
                units_next  = units_full[emabd_pkg::DIGIT_BITS-1:0];
                tenths_next = tenths_full[emabd_pkg::DIGIT_BITS-1:0];
                band_next   = band_calc;
            end
            else
            begin
                scan_next = (scan_reg >= emabd_pkg::SCAN_TENTHS) ?
                            emabd_pkg::SCAN_TENS : scan_reg + 2'd1;
            end
        end
    end

    // Result transaction from the updated state
    always_comb
    begin
        out_next.band         = band_next;
        out_next.red_duty     = (band_next == emabd_pkg::BAND_RED)   ? cfg.led_duty : '0;
        out_next.green_duty   = (band_next == emabd_pkg::BAND_GREEN) ? cfg.led_duty : '0;
        out_next.blue_duty    = (band_next == emabd_pkg::BAND_BLUE)  ? cfg.led_duty : '0;
        case (band_next)
            emabd_pkg::BAND_GREEN: out_next.servo_duty = cfg.servo_low;
            emabd_pkg::BAND_BLUE:  out_next.servo_duty = cfg.servo_mid;
            emabd_pkg::BAND_RED:   out_next.servo_duty = cfg.servo_high;
            default:               out_next.servo_duty = '0;
        endcase
        out_next.tens_digit   = tens_next;
        out_next.units_digit  = units_next;
        out_next.tenths_digit = tenths_next;
        out_next.filtered_mv  = mv;
        case (scan_next)
            emabd_pkg::SCAN_UNITS:
            begin
                out_next.digit_enable = 3'b010;
                out_next.shown_digit  = emabd_pkg::TENS_BITS'(units_next);
                out_next.point_on     = 1'b1;
            end
            emabd_pkg::SCAN_TENTHS:
            begin
                out_next.digit_enable = 3'b100;
                out_next.shown_digit  = emabd_pkg::TENS_BITS'(tenths_next);
                out_next.point_on     = 1'b0;
            end
            default:
            begin
                out_next.digit_enable = 3'b001;
                out_next.shown_digit  = tens_next;
                out_next.point_on     = 1'b0;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            scan_reg      <= emabd_pkg::SCAN_TENS;
            tens_reg      <= '0;
            units_reg     <= '0;
            tenths_reg    <= '0;
            band_reg      <= emabd_pkg::BAND_NONE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            tens_reg      <= tens_next;
            units_reg     <= units_next;
            tenths_reg    <= tenths_next;
            band_reg      <= band_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    // Scan never reaches the unused position
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg != 2'd3)
        else $error("scan position out of range");

    // Decimal point goes with the units digit only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($onehot(out_reg.digit_enable) &&
                           (out_reg.point_on == out_reg.digit_enable[1])))
        else $error("digit select or point inconsistent");

    // Once a sample has been taken a band is always set
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && is_sample) |=> (band_reg != emabd_pkg::BAND_NONE))
        else $error("band missing after sample");

    // Decimal digits stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.units_digit <= 4'd9) && (out_reg.tenths_digit <= 4'd9)))
        else $error("digit out of range");

endmodule
